>>> sv/agacc_pkg.sv
`default_nettype none
package agacc_pkg;

   // command codes
   localparam logic [2:0] CMD_STORE  = 3'd0;
   localparam logic [2:0] CMD_ACCUM  = 3'd1;
   localparam logic [2:0] CMD_CLR_G  = 3'd2;
   localparam logic [2:0] CMD_CLR_F  = 3'd3;
   localparam logic [2:0] CMD_NORM   = 3'd4;
   localparam logic [2:0] CMD_UPDATE = 3'd5;

   // register indexes
   localparam logic [1:0] REG_GAIN  = 2'd0;
   localparam logic [1:0] REG_PMIN  = 2'd1;
   localparam logic [1:0] REG_PMAX  = 2'd2;
   localparam logic [1:0] REG_VCNT  = 2'd3;

   localparam int PERM_W = 24;
   localparam int GRAD_W = 56;
   localparam int DELTA_W = 27;
   localparam int QUO_W = 72;
   localparam logic [25:0] DELTA_CAP = 26'h2000000;

   typedef struct packed {
      logic [2:0]         command;
      logic [9:0]         voxel;
      logic [4:0]         time_step;
      logic signed [23:0] field_x;
      logic signed [23:0] field_y;
      logic signed [23:0] field_z;
      logic [23:0]        perm_x;
      logic [23:0]        perm_y;
      logic [23:0]        perm_z;
   } req_type;

   typedef struct packed {
      logic [23:0]        new_perm_x;
      logic [23:0]        new_perm_y;
      logic [23:0]        new_perm_z;
      logic signed [55:0] gradient_value;
      logic               saturated;
      logic               zero_norm;
   } rsp_type;

   typedef struct packed {
      logic [23:0] perm_min;
      logic [23:0] perm_max;
   } limit_type;

endpackage
`default_nettype wire

>>> sv/adjoint_gradient_accumulator.sv
// Adjoint gradient accumulator.
// Input channel req_* (valid/ready) carries one command beat; result channel
// rsp_* (valid/ready) returns exactly one beat per command. csr_* writes the
// gain, permittivity limits and voxel count; the user must use it only while
// idle, and the block itself does not enforce that. Commands run one at a
// time through a sequencer; update uses a bit-serial divider. With
// n = min(voxel_count, VOXELS): clear gradient writes n words, clear
// forward n*STEPS words, norm reads n words (one memory word per cycle).
// The three field components go through three lanes side by side; their
// products are merged in one saturating add into the gradient.
// Reset: a clearing pass writes zero to all VOXELS*STEPS forward words (and
// the VOXELS gradient words alongside), with req_ready low; registers take
// their reset values at once.
// A finished result waits in the output register while rsp_ready is low;
// a new command may be accepted then, but it finishes only after the
// waiting beat leaves.
`default_nettype none
module adjoint_gradient_accumulator import agacc_pkg::*; #(
   parameter int VOXELS = 1024,
   parameter int STEPS = 32,
   parameter int FIELD_BITS = 24
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_data,
   input  wire          csr_we,
   input  wire [1:0]    csr_index,
   input  wire [31:0]   csr_wdata
);
   localparam int FB = FIELD_BITS;
   localparam int FDEPTH = VOXELS * STEPS;
   localparam int FAW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int GAW = (VOXELS > 1) ? $clog2(VOXELS) : 1;
   localparam int CW = $clog2(FDEPTH + 1);
   localparam int SUM_W = GRAD_W + 2 * FB + 2;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_EXEC  = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_ACC   = 4'd4;
   localparam logic [3:0] ST_NORM  = 4'd5;
   localparam logic [3:0] ST_PROD  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_CLAMP = 4'd8;
   localparam logic [3:0] ST_READ  = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // configuration
   logic [31:0] gain_ff;
   logic [23:0] pmin_ff, pmax_ff;
   logic [10:0] vcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 32'd65536;
         pmin_ff <= 24'd65536;
         pmax_ff <= 24'd1048576;
         vcnt_ff <= 11'd1024;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN: gain_ff <= csr_wdata;
            REG_PMIN: pmin_ff <= csr_wdata[23:0];
            REG_PMAX: pmax_ff <= csr_wdata[23:0];
            REG_VCNT: vcnt_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   logic [3:0]  state_ff, state_in;
   req_type     item_ff;
   logic [CW-1:0] cnt_ff, lim_ff;
   logic        boot_ff, clr_f_ff, clr_g_ff;
   logic        sat_ff, zn_ff, neg_ff;
   logic [63:0] sum_ff, acc_ff, sq_ff;
   logic        nv1_ff, nv2_ff;
   logic [23:0] perm_ff [3];
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   logic [3*FB-1:0] fwd_rd_ff;
   logic signed [GRAD_W-1:0] grad_rd_ff;

   logic vox_ok, ts_ok, acc_ok;
   logic [CW-1:0] walk_n;
   logic [FAW-1:0] faddr;
   logic [GAW-1:0] gaddr;
   logic out_free;

   assign vox_ok = 32'(item_ff.voxel) < VOXELS;
   assign ts_ok = 32'(item_ff.time_step) < STEPS;
   assign acc_ok = vox_ok && ts_ok;
   assign walk_n = (32'(vcnt_ff) > VOXELS) ? CW'(VOXELS) : CW'(vcnt_ff);
   assign faddr = FAW'(32'(item_ff.voxel) * STEPS + 32'(item_ff.time_step));
   assign gaddr = GAW'(item_ff.voxel);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // forward field memory
   logic [3*FB-1:0] fwd_mem [FDEPTH];
   logic            fwd_we, fwd_re;
   logic [FAW-1:0]  fwd_wa;
   logic [3*FB-1:0] fwd_wd;

   always_comb begin
      fwd_we = 1'b0;
      fwd_wa = faddr;
      fwd_wd = {item_ff.field_z[FB-1:0], item_ff.field_y[FB-1:0],
                item_ff.field_x[FB-1:0]};
      if (state_ff == ST_EXEC && item_ff.command == CMD_STORE && acc_ok) begin
         fwd_we = 1'b1;
      end else if (state_ff == ST_CLEAR && clr_f_ff && cnt_ff != lim_ff) begin
         fwd_we = 1'b1;
         fwd_wa = cnt_ff[FAW-1:0];
         fwd_wd = '0;
      end
   end
   assign fwd_re = state_ff == ST_EXEC && item_ff.command == CMD_ACCUM && acc_ok;

   always_ff @(posedge clock) begin
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      if (fwd_re) fwd_rd_ff <= fwd_mem[faddr];
   end

   // gradient memory
   logic signed [GRAD_W-1:0] grad_mem [VOXELS];
   logic                     grad_we;
   logic [GAW-1:0]           grad_wa, grad_ra;
   logic signed [GRAD_W-1:0] grad_wd, acc_res;
   logic                     acc_sat;

   always_comb begin
      grad_we = 1'b0;
      grad_wa = gaddr;
      grad_wd = acc_res;
      if (state_ff == ST_ACC) begin
         grad_we = 1'b1;
      end else if (state_ff == ST_CLEAR && clr_g_ff && cnt_ff != lim_ff &&
                   cnt_ff < CW'(VOXELS)) begin
         grad_we = 1'b1;
         grad_wa = cnt_ff[GAW-1:0];
         grad_wd = '0;
      end
      grad_ra = (state_ff == ST_NORM) ? cnt_ff[GAW-1:0] : gaddr;
   end

   always_ff @(posedge clock) begin
      if (grad_we) grad_mem[grad_wa] <= grad_wd;
      grad_rd_ff <= grad_mem[grad_ra];
   end

   // three lanes: products and clamps
   logic signed [2*FB-1:0] prod [3];
   logic [23:0]            perm_new [3];
   logic [63:0]            quo_cap;
   logic signed [DELTA_W-1:0] delta;
   logic [QUO_W-1:0]       quo;
   logic                   div_done;
   logic signed [FB-1:0]   fld [3];
   limit_type              lim;

   assign fld[0] = item_ff.field_x[FB-1:0];
   assign fld[1] = item_ff.field_y[FB-1:0];
   assign fld[2] = item_ff.field_z[FB-1:0];
   assign lim.perm_min = pmin_ff;
   assign lim.perm_max = pmax_ff;
   assign delta = neg_ff ? -$signed({1'b0, quo_cap[25:0]})
                         : $signed({1'b0, quo_cap[25:0]});
   assign quo_cap = (quo > QUO_W'(DELTA_CAP)) ? 64'(DELTA_CAP) : quo[63:0];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      agacc_lane #(.FB(FB)) u_lane (
         .clock  (clock),
         .mul_en (state_ff == ST_MUL),
         .fwd    (fwd_rd_ff[k*FB +: FB]),
         .fld    (fld[k]),
         .perm   (perm_ff[k]),
         .delta  (delta),
         .lim    (lim),
         .prod_o (prod[k]),
         .perm_o (perm_new[k])
      );
   end

   // merge: exact sum of gradient and lane products, saturated to 56 bits
   logic signed [SUM_W-1:0] wide;
   always_comb begin
      wide = SUM_W'(grad_rd_ff) + SUM_W'(prod[0]) + SUM_W'(prod[1]) +
             SUM_W'(prod[2]);
      acc_sat = 1'b0;
      acc_res = wide[GRAD_W-1:0];
      if (wide > $signed(SUM_W'({1'b0, {(GRAD_W-1){1'b1}}}))) begin
         acc_res = {1'b0, {(GRAD_W-1){1'b1}}};
         acc_sat = 1'b1;
      end else if (wide < -$signed(SUM_W'({1'b1, {(GRAD_W-1){1'b0}}}))) begin
         acc_res = {1'b1, {(GRAD_W-1){1'b0}}};
         acc_sat = 1'b1;
      end
   end

   // update step numerator, taken by the divider as it starts
   logic signed [31:0] h_upd, h_norm;
   logic [31:0]        mag;
   logic [63:0]        num_w;
   assign h_upd = vox_ok ? 32'(grad_rd_ff >>> 24) : 32'sd0;
   assign h_norm = 32'(grad_rd_ff >>> 24);
   assign mag = h_upd[31] ? 32'(-h_upd) : h_upd;
   assign num_w = 64'(gain_ff) * 64'(mag);

   agacc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_PROD),
      .num   (num_w),
      .den   (sum_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // sequencer
   logic norm_end;
   assign norm_end = cnt_ff == lim_ff && !nv1_ff && !nv2_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (cnt_ff == lim_ff) state_in = boot_ff ? ST_IDLE : ST_READ;
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (item_ff.command)
               CMD_ACCUM:  state_in = acc_ok ? ST_MUL : ST_READ;
               CMD_CLR_G, CMD_CLR_F: state_in = ST_CLEAR;
               CMD_NORM:   state_in = ST_NORM;
               CMD_UPDATE: state_in = (sum_ff == 64'd0) ? ST_READ : ST_PROD;
               default:    state_in = ST_READ;
            endcase
         end
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_READ;
         ST_NORM:  if (norm_end) state_in = ST_READ;
         ST_PROD:  state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_READ;
         ST_READ:  state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         boot_ff <= 1'b1;
         clr_f_ff <= 1'b1;
         clr_g_ff <= 1'b1;
         cnt_ff <= '0;
         lim_ff <= CW'(FDEPTH);
         sum_ff <= '0;
         nv1_ff <= 1'b0;
         nv2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // result beat: load wins over drain
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               if (cnt_ff != lim_ff) cnt_ff <= cnt_ff + 1'b1;
               else boot_ff <= 1'b0;
            end
            ST_EXEC: begin
               cnt_ff <= '0;
               nv1_ff <= 1'b0;
               nv2_ff <= 1'b0;
               clr_g_ff <= item_ff.command == CMD_CLR_G;
               clr_f_ff <= item_ff.command == CMD_CLR_F;
               lim_ff <= (item_ff.command == CMD_CLR_F)
                         ? CW'(32'(walk_n) * STEPS) : walk_n;
            end
            ST_NORM: begin
               nv1_ff <= cnt_ff != lim_ff;
               nv2_ff <= nv1_ff;
               if (cnt_ff != lim_ff) cnt_ff <= cnt_ff + 1'b1;
               if (norm_end) sum_ff <= acc_ff;
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            item_ff <= req_data;
            perm_ff[0] <= req_data.perm_x;
            perm_ff[1] <= req_data.perm_y;
            perm_ff[2] <= req_data.perm_z;
            sat_ff <= 1'b0;
            zn_ff <= 1'b0;
            acc_ff <= '0;
         end
         ST_EXEC: begin
            if (item_ff.command == CMD_UPDATE && sum_ff == 64'd0) zn_ff <= 1'b1;
         end
         ST_ACC: sat_ff <= acc_sat;
         ST_NORM: begin
            sq_ff <= 64'(h_norm * h_norm);
            if (nv2_ff) begin
               if (acc_ff > ~sq_ff) begin
                  acc_ff <= '1;
                  sat_ff <= 1'b1;
               end else begin
                  acc_ff <= acc_ff + sq_ff;
               end
            end
         end
         ST_PROD: begin
            neg_ff <= h_upd[31];
         end
         ST_CLAMP: begin
            perm_ff[0] <= perm_new[0];
            perm_ff[1] <= perm_new[1];
            perm_ff[2] <= perm_new[2];
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_ff.new_perm_x <= perm_ff[0];
               rsp_ff.new_perm_y <= perm_ff[1];
               rsp_ff.new_perm_z <= perm_ff[2];
               rsp_ff.gradient_value <= vox_ok ? grad_rd_ff : '0;
               rsp_ff.saturated <= sat_ff;
               rsp_ff.zero_norm <= zn_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_boot: assert property (@(posedge clock)
      reset |=> !req_ready) else $error("ready during clearing pass");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC) else $error("accept lost");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.saturated && rsp_data.zero_norm))
      else $error("both flags set");
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("stray divide");
endmodule
`default_nettype wire

>>> sv/agacc_lane.sv
`default_nettype none
module agacc_lane import agacc_pkg::*; #(
   parameter int FB = 24
) (
   input  wire                        clock,
   input  wire                        mul_en,
   input  wire logic signed [FB-1:0]  fwd,
   input  wire logic signed [FB-1:0]  fld,
   input  wire logic [PERM_W-1:0]     perm,
   input  wire logic signed [DELTA_W-1:0] delta,
   input  wire limit_type             lim,
   output logic signed [2*FB-1:0]     prod_o,
   output logic [PERM_W-1:0]          perm_o
);
   logic signed [2*FB-1:0]    prod_ff;
   logic signed [DELTA_W-1:0] sum;
   logic signed [DELTA_W-1:0] lo;
   logic signed [DELTA_W-1:0] hi;

   // forward times adjoint product, registered
   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= fwd * fld;
   end
   assign prod_o = prod_ff;

   // step then clamp: raise to min first, then lower to max
   always_comb begin
      sum = $signed({3'b000, perm}) + delta;
      lo = $signed({3'b000, lim.perm_min});
      hi = $signed({3'b000, lim.perm_max});
      if (sum < lo) sum = lo;
      if (sum > hi) sum = hi;
      perm_o = sum[PERM_W-1:0];
   end
endmodule
`default_nettype wire

>>> sv/agacc_div.sv
`default_nettype none
module agacc_div import agacc_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);
   logic [QUO_W-1:0] dvd_ff;
   logic [63:0]      rem_ff;
   logic [6:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [64:0]      trial;
   logic             fit;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, dvd_ff[QUO_W-1]};
      fit = trial >= {1'b0, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 7'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num, 8'h00};
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fit ? 64'(trial - {1'b0, den}) : trial[63:0];
         dvd_ff <= {dvd_ff[QUO_W-2:0], fit};
      end
   end

   assign done = done_ff;
   assign quo = dvd_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("divider done while busy");
endmodule
`default_nettype wire

>>> tb/agacc_checker.sv
`default_nettype none
module agacc_checker import agacc_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire          req_ready,
   input  wire req_type req_data,
   input  wire          rsp_valid,
   input  wire          rsp_ready,
   input  wire rsp_type rsp_data,
   input  wire          csr_we,
   input  wire [1:0]    csr_index,
   input  wire [31:0]   csr_wdata,
   output int           errors,
   output int           pending,
   output int           sat_seen,
   output int           zero_seen
);

   localparam int NVOX = 1024;
   localparam int NSTEP = 32;
   localparam longint GRAD_HI = 64'sh007F_FFFF_FFFF_FFFF;
   localparam longint GRAD_LO = -GRAD_HI - 1;

   // shadow of the block's stores and registers
   logic signed [23:0] fwd_x [NVOX*NSTEP];
   logic signed [23:0] fwd_y [NVOX*NSTEP];
   logic signed [23:0] fwd_z [NVOX*NSTEP];
   logic signed [55:0] grad [NVOX];
   logic [63:0]        sq_sum;
   logic [31:0]        gain;
   logic [23:0]        pmin, pmax;
   logic [10:0]        vcount;

   rsp_type expected_q [$];

   task automatic report(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic int walk_len();
      return (vcount > NVOX) ? NVOX : int'(vcount);
   endfunction

   function automatic logic [23:0] clamp(input logic [23:0] p, input longint d);
      longint v;
      v = longint'({40'd0, p}) + d;
      if (v < longint'({40'd0, pmin})) v = longint'({40'd0, pmin});
      if (v > longint'({40'd0, pmax})) v = longint'({40'd0, pmax});
      return v[23:0];
   endfunction

   // apply one command to the shadow state, return the beat it should produce
   function automatic rsp_type apply_command(input req_type r);
      rsp_type    o;
      int         a, n;
      longint     acc, h, sd;
      logic [64:0] s;
      logic [63:0] q, mag, num;
      logic [71:0] dq;
      o = '0;
      o.new_perm_x = r.perm_x;
      o.new_perm_y = r.perm_y;
      o.new_perm_z = r.perm_z;
      a = int'(r.voxel) * NSTEP + int'(r.time_step);
      n = walk_len();
      case (r.command)
         CMD_STORE: begin
            fwd_x[a] = r.field_x;
            fwd_y[a] = r.field_y;
            fwd_z[a] = r.field_z;
         end
         CMD_ACCUM: begin
            acc = longint'(grad[r.voxel])
                + longint'(fwd_x[a]) * longint'(r.field_x)
                + longint'(fwd_y[a]) * longint'(r.field_y)
                + longint'(fwd_z[a]) * longint'(r.field_z);
            if (acc > GRAD_HI) begin
               acc = GRAD_HI;
               o.saturated = 1'b1;
            end else if (acc < GRAD_LO) begin
               acc = GRAD_LO;
               o.saturated = 1'b1;
            end
            grad[r.voxel] = acc[55:0];
         end
         CMD_CLR_G: for (int i = 0; i < n; i++) grad[i] = '0;
         CMD_CLR_F: begin
            for (int i = 0; i < n * NSTEP; i++) begin
               fwd_x[i] = '0;
               fwd_y[i] = '0;
               fwd_z[i] = '0;
            end
         end
         CMD_NORM: begin
            s = '0;
            for (int i = 0; i < n; i++) begin
               h = longint'(grad[i]) >>> 24;
               q = h * h;
               s = s + {1'b0, q};
               if (s[64]) begin
                  s = {1'b0, {64{1'b1}}};
                  o.saturated = 1'b1;
               end
            end
            sq_sum = s[63:0];
         end
         CMD_UPDATE: begin
            if (sq_sum == 0) begin
               o.zero_norm = 1'b1;
            end else begin
               h = longint'(grad[r.voxel]) >>> 24;
               mag = (h < 0) ? -h : h;
               num = {32'd0, gain} * mag;
               dq = {num, 8'd0} / {8'd0, sq_sum};
               if (dq > 72'h200_0000) dq = 72'h200_0000;
               sd = (h < 0) ? -longint'(dq[25:0]) : longint'(dq[25:0]);
               o.new_perm_x = clamp(r.perm_x, sd);
               o.new_perm_y = clamp(r.perm_y, sd);
               o.new_perm_z = clamp(r.perm_z, sd);
            end
         end
         default: ;
      endcase
      o.gradient_value = grad[r.voxel];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NVOX * NSTEP; i++) begin
            fwd_x[i] = '0;
            fwd_y[i] = '0;
            fwd_z[i] = '0;
         end
         for (int i = 0; i < NVOX; i++) grad[i] = '0;
         sq_sum = '0;
         gain = 32'd65536;
         pmin = 24'd65536;
         pmax = 24'd1048576;
         vcount = 11'd1024;
         expected_q.delete();
         errors = 0;
         sat_seen = 0;
         zero_seen = 0;
      end else begin
         // result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("result beat with nothing outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.new_perm_x !== want.new_perm_x)
                  report($sformatf("new_perm_x %h exp %h", rsp_data.new_perm_x, want.new_perm_x));
               if (rsp_data.new_perm_y !== want.new_perm_y)
                  report($sformatf("new_perm_y %h exp %h", rsp_data.new_perm_y, want.new_perm_y));
               if (rsp_data.new_perm_z !== want.new_perm_z)
                  report($sformatf("new_perm_z %h exp %h", rsp_data.new_perm_z, want.new_perm_z));
               if (rsp_data.gradient_value !== want.gradient_value)
                  report($sformatf("gradient_value %h exp %h",
                                   rsp_data.gradient_value, want.gradient_value));
               if (rsp_data.saturated !== want.saturated)
                  report($sformatf("saturated %b exp %b", rsp_data.saturated, want.saturated));
               if (rsp_data.zero_norm !== want.zero_norm)
                  report($sformatf("zero_norm %b exp %b", rsp_data.zero_norm, want.zero_norm));
               if (want.saturated) sat_seen++;
               if (want.zero_norm) zero_seen++;
            end
         end
         // command beat -> prediction
         if (req_valid && req_ready) expected_q.push_back(apply_command(req_data));
         // register writes
         if (csr_we) begin
            case (csr_index)
               REG_GAIN: gain = csr_wdata;
               REG_PMIN: pmin = csr_wdata[23:0];
               REG_PMAX: pmax = csr_wdata[23:0];
               REG_VCNT: vcount = csr_wdata[10:0];
               default: ;
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule
`default_nettype wire

>>> tb/tb_adjoint_gradient_accumulator.sv
`default_nettype none
module tb_adjoint_gradient_accumulator;
   import agacc_pkg::*;

   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam int QUIET_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 44;
   localparam logic signed [23:0] F_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] F_MIN = -24'sh800000;

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready;
   req_type     req_data;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          errors, pending, sat_seen, zero_seen;

   int snd_idle, rcv_idle, span, beats_sent, settings;
   int quiet = 0;
   bit holdoff;

   adjoint_gradient_accumulator DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   agacc_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .errors, .pending, .sat_seen, .zero_seen
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      bit held;
      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff && !held) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb_adjoint_gradient_accumulator: FAIL");
         $finish;
      end
   end

   task automatic send(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] g, input logic [23:0] lo,
                            input logic [23:0] hi, input logic [10:0] vc);
      drain();
      write_reg(REG_GAIN, g);
      write_reg(REG_PMIN, {8'd0, lo});
      write_reg(REG_PMAX, {8'd0, hi});
      write_reg(REG_VCNT, {21'd0, vc});
      settings++;
   endtask

   function automatic req_type make_cmd(input logic [2:0] c, input logic [9:0] v,
                                        input logic [4:0] t, input logic signed [23:0] fx,
                                        input logic signed [23:0] fy,
                                        input logic signed [23:0] fz);
      req_type r;
      r.command = c;
      r.voxel = v;
      r.time_step = t;
      r.field_x = fx;
      r.field_y = fy;
      r.field_z = fz;
      r.perm_x = 24'($urandom);
      r.perm_y = 24'($urandom);
      r.perm_z = 24'($urandom);
      return r;
   endfunction

   function automatic logic [23:0] field_pick();
      case ($urandom_range(15))
         0: return F_MAX;
         1: return F_MIN;
         2: return 24'd0;
         3: return 24'($urandom_range(255));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type random_cmd();
      req_type r;
      int roll;
      roll = $urandom_range(99);
      r = make_cmd(CMD_ACCUM, '0, '0, field_pick(), field_pick(), field_pick());
      if (roll < 30) r.command = CMD_STORE;
      else if (roll < 70) r.command = CMD_ACCUM;
      else if (roll < 84) r.command = CMD_UPDATE;
      else if (roll < 92) r.command = CMD_NORM;
      else if (roll < 95) r.command = CMD_CLR_G;
      else if (roll < 96) r.command = CMD_CLR_F;
      else if (roll < 98) r.command = CMD_SPARE_A;
      else r.command = CMD_SPARE_B;
      r.voxel = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(span - 1));
      r.time_step = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
      if ($urandom_range(7) == 0) r.perm_x = '1;
      if ($urandom_range(7) == 0) r.perm_y = '0;
      return r;
   endfunction

   task automatic random_phase(input int n);
      repeat (n) send(random_cmd());
   endtask

   initial begin
      req_type r;
      logic signed [23:0] adj;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      snd_idle = 0;
      rcv_idle = 0;
      span = 8;
      beats_sent = 0;
      settings = 0;
      holdoff = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty sum, corner addresses, spare codes
      send(make_cmd(CMD_UPDATE, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_STORE, 10'd0, 5'd0, F_MAX, F_MAX, F_MAX));
      send(make_cmd(CMD_ACCUM, 10'd0, 5'd0, F_MAX, F_MIN, F_MAX));
      send(make_cmd(CMD_STORE, 10'd1023, 5'd31, F_MIN, F_MIN, F_MIN));
      send(make_cmd(CMD_ACCUM, 10'd1023, 5'd31, F_MIN, F_MAX, F_MIN));
      send(make_cmd(CMD_ACCUM, 10'd5, 5'd7, F_MAX, F_MAX, F_MAX));
      send(make_cmd(CMD_SPARE_A, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_SPARE_B, 10'd1023, 5'd31, F_MIN, F_MIN, F_MIN));
      send(make_cmd(CMD_NORM, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_UPDATE, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_UPDATE, 10'd1023, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_CLR_G, 10'd0, 5'd0, '0, '0, '0));

      // drive five gradients to the rails, then a sum that overflows
      for (int v = 0; v < 5; v++) begin
         send(make_cmd(CMD_STORE, 10'(v), 5'd0, F_MIN, F_MIN, F_MIN));
         adj = (v < 2) ? F_MIN : F_MAX;
         repeat (172) send(make_cmd(CMD_ACCUM, 10'(v), 5'd0, adj, adj, adj));
      end
      send(make_cmd(CMD_NORM, 10'd0, 5'd0, '0, '0, '0));
      for (int v = 0; v < 5; v++) begin
         r = make_cmd(CMD_UPDATE, 10'(v), 5'd0, '0, '0, '0);
         r.perm_x = '0;
         r.perm_y = '1;
         send(r);
      end
      send(make_cmd(CMD_CLR_F, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_ACCUM, 10'd0, 5'd0, F_MAX, F_MAX, F_MAX));
      send(make_cmd(CMD_CLR_G, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_NORM, 10'd0, 5'd0, '0, '0, '0));
      send(make_cmd(CMD_UPDATE, 10'd0, 5'd0, '0, '0, '0));

      // random phases over several register settings
      configure(32'd65536, 24'd65536, 24'd1048576, 11'd8);
      span = 8;
      random_phase(PHASE_ITEMS);

      configure(32'hFFFF_FFFF, 24'd0, 24'hFF_FFFF, 11'd1);
      snd_idle = 79;
      span = 2;
      random_phase(PHASE_ITEMS);

      configure(32'd0, 24'hFF_FFFF, 24'd0, 11'd0);
      snd_idle = 0;
      rcv_idle = 79;
      span = 4;
      random_phase(PHASE_ITEMS);

      configure($urandom, 24'h01_0000, 24'h20_0000, 11'd2047);
      snd_idle = 14;
      rcv_idle = 14;
      span = 16;
      random_phase(PHASE_ITEMS);

      // long result stall with the sender still pushing
      configure(32'h0001_2345, 24'($urandom), 24'($urandom), 11'd16);
      snd_idle = 0;
      rcv_idle = 0;
      holdoff = 1'b1;
      random_phase(PHASE_ITEMS);

      configure(32'h0004_0000, 24'h00_8000, 24'hC0_0000, 11'd12);
      snd_idle = 14;
      rcv_idle = 14;
      span = 12;
      random_phase(PHASE_ITEMS);

      drain();
      repeat (200) @(negedge clock);
      $display("run covered %0d command beats under %0d register settings", beats_sent,
               settings);
      $display("saturating results %0d, empty-sum updates %0d, mismatches %0d",
               sat_seen, zero_seen, errors);
      if (errors == 0 && pending == 0) begin
         $display("tb_adjoint_gradient_accumulator: PASS");
      end else begin
         $display("tb_adjoint_gradient_accumulator: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
sv/agacc_pkg.sv
sv/agacc_lane.sv
sv/agacc_div.sv
sv/adjoint_gradient_accumulator.sv
tb/agacc_checker.sv
tb/tb_adjoint_gradient_accumulator.sv
